>>> rtl/pphd_pkg.sv
// shared types and constants for the position pid h-bridge drive
package pphd_pkg;

    // stream and configuration port widths
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // field widths
    localparam int POS_W   = 8;
    localparam int KP_W    = 14;
    localparam int KI_W    = 13;
    localparam int KD_W    = 11;
    localparam int DIST_W  = 11;
    localparam int DRV_W   = 11;
    localparam int DUTY_W  = 10;
    localparam int ERR_W   = 9;
    localparam int DIFF_W  = 10;

    // filtered derivative, signed q12.8, saturating
    localparam int DERIV_W = 20;
    localparam int DQ_W    = 22;
    localparam logic signed [DQ_W-1:0] DERIV_HI = DQ_W'(524287);
    localparam logic signed [DQ_W-1:0] DERIV_LO = -DQ_W'(524287);

    // shared multiplier operand and product widths
    localparam int MUL_W  = 25;
    localparam int PROD_W = 2 * MUL_W;
    localparam logic signed [MUL_W-1:0] DFILT_COEF = MUL_W'(179);

    // weighted sum, sized for the largest supported integral limit
    localparam int SUM_W  = 40;
    localparam int SCALE_SHIFT = 16;
    localparam int QUO_W  = SUM_W - SCALE_SHIFT;

    // divide by ten as multiply by ceil(2^27/10), exact below 2^26
    localparam logic signed [MUL_W-1:0] RECIP_TEN = MUL_W'(13421773);
    localparam int RECIP_SHIFT = 27;
    localparam int QUOT_W = 21;

    // drive before saturation: quotient plus disturbance
    localparam int OUT_W = 23;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KI     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIST   = 3'd4;

    // register reset values
    localparam logic [KP_W-1:0] KP_RESET = 14'd1024;
    localparam logic [KI_W-1:0] KI_RESET = 13'd1152;
    localparam logic [KD_W-1:0] KD_RESET = 11'd51;

    typedef struct packed {
        logic [POS_W-1:0]         target_position;
        logic [KP_W-1:0]          prop_gain;
        logic [KI_W-1:0]          integ_gain;
        logic [KD_W-1:0]          deriv_gain;
        logic signed [DIST_W-1:0] disturbance_offset;
    } cfg_regs_t;

    // one strobe per sequencer step
    typedef struct packed {
        logic idle;
        logic do_dfilt;
        logic do_prop;
        logic do_integ;
        logic do_deriv;
        logic do_sum;
        logic do_abs;
        logic do_div;
        logic do_out;
    } seq_ctrl_t;

endpackage

>>> rtl/pphd_cfg.sv
// configuration register file for the drive controller
module pphd_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                wr_en,
    input  logic [pphd_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [pphd_pkg::CFG_DATA_W-1:0]     wr_data,
    output pphd_pkg::cfg_regs_t                 regs
);

    pphd_pkg::cfg_regs_t regs_reg;
    pphd_pkg::cfg_regs_t regs_next;

    // decode the index, keep only each register's width
    always_comb begin
        regs_next = regs_reg;
        if (wr_en) begin
            case (wr_index)
                pphd_pkg::REG_TARGET: regs_next.target_position =
                    wr_data[pphd_pkg::POS_W-1:0];
                pphd_pkg::REG_KP: regs_next.prop_gain = wr_data[pphd_pkg::KP_W-1:0];
                pphd_pkg::REG_KI: regs_next.integ_gain = wr_data[pphd_pkg::KI_W-1:0];
                pphd_pkg::REG_KD: regs_next.deriv_gain = wr_data[pphd_pkg::KD_W-1:0];
                pphd_pkg::REG_DIST: regs_next.disturbance_offset =
                    $signed(wr_data[pphd_pkg::DIST_W-1:0]);
                default: regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg.target_position    <= '0;
            regs_reg.prop_gain          <= pphd_pkg::KP_RESET;
            regs_reg.integ_gain         <= pphd_pkg::KI_RESET;
            regs_reg.deriv_gain         <= pphd_pkg::KD_RESET;
            regs_reg.disturbance_offset <= '0;
        end else begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

>>> rtl/pphd_mul.sv
// shared signed multiplier with registered product
module pphd_mul (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [pphd_pkg::MUL_W-1:0]   op_a,
    input  logic signed [pphd_pkg::MUL_W-1:0]   op_b,
    output logic signed [pphd_pkg::PROD_W-1:0]  prod
);

    logic signed [pphd_pkg::PROD_W-1:0] prod_reg;
    logic signed [pphd_pkg::PROD_W-1:0] prod_next;

    // full-width signed product
    always_comb begin
        prod_next = op_a * op_b;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

>>> rtl/pphd_seq.sv
// step sequencer for one control tick
module pphd_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic                zero_sp,
    input  logic                out_free,
    output pphd_pkg::seq_ctrl_t ctrl
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_DFILT = 9'b000000010,
        ST_PROP  = 9'b000000100,
        ST_INTEG = 9'b000001000,
        ST_DERIV = 9'b000010000,
        ST_SUM   = 9'b000100000,
        ST_ABS   = 9'b001000000,
        ST_DIV   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // a zero setpoint skips the arithmetic
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = zero_sp ? ST_OUT : ST_DFILT;
                end
            end
            ST_DFILT: state_next = ST_PROP;
            ST_PROP:  state_next = ST_INTEG;
            ST_INTEG: state_next = ST_DERIV;
            ST_DERIV: state_next = ST_SUM;
            ST_SUM:   state_next = ST_ABS;
            ST_ABS:   state_next = ST_DIV;
            ST_DIV:   state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // step strobes
    always_comb begin
        ctrl.idle     = (state_reg == ST_IDLE);
        ctrl.do_dfilt = (state_reg == ST_DFILT);
        ctrl.do_prop  = (state_reg == ST_PROP);
        ctrl.do_integ = (state_reg == ST_INTEG);
        ctrl.do_deriv = (state_reg == ST_DERIV);
        ctrl.do_sum   = (state_reg == ST_SUM);
        ctrl.do_abs   = (state_reg == ST_ABS);
        ctrl.do_div   = (state_reg == ST_DIV);
        ctrl.do_out   = (state_reg == ST_OUT);
    end

endmodule

>>> rtl/pid_position_hbridge_drive_unit.sv
// top level of the position pid controller with h-bridge duty split
//
// One measured position enters per word on the s_ stream; one result word
// leaves on the m_ stream for each. Gains, setpoint and disturbance sit in
// registers written over the cfg_ channel (always ready); the user must
// write them only while idle, as the block itself does not enforce it.
// A tick runs on one shared 25x25 multiplier under a step sequencer:
// derivative filter, proportional, integral and derivative products, then
// a divide by ten as a reciprocal multiply. The result word becomes valid
// as the sequencer leaves its last step, and s_tready rises in that same
// cycle, so the block takes no new word while one is in work. With a zero
// setpoint the arithmetic is skipped: the sequencer goes from idle straight
// to its last step. If the receiver stalls, the result holds in the output
// register and the sequencer waits in its last step; s_tready stays low
// until it is taken. Reset clears the integral, the filtered derivative and
// the last error, loads the register defaults and empties the output register.
module pid_position_hbridge_drive_unit #(
    parameter int DRIVE_LIMIT    = 1023,
    parameter int INTEGRAL_LIMIT = 512
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [pphd_pkg::IN_DATA_W-1:0]      s_tdata,  // [7:0] measured_position
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [10:0] drive_value, [20:11] forward_duty, [30:21] backward_duty,
    // [39:31] position_error
    output logic [pphd_pkg::OUT_DATA_W-1:0]     m_tdata,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pphd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pphd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int ILIM10 = INTEGRAL_LIMIT * 10;
    localparam int IW = $clog2(ILIM10 + 1) + 1;
    localparam logic signed [IW:0] IT_HI = (IW+1)'(ILIM10);
    localparam logic signed [IW:0] IT_LO = -((IW+1)'(ILIM10));
    localparam logic signed [pphd_pkg::OUT_W-1:0] DRV_HI =
        pphd_pkg::OUT_W'(DRIVE_LIMIT);
    localparam logic signed [pphd_pkg::OUT_W-1:0] DRV_LO =
        -(pphd_pkg::OUT_W'(DRIVE_LIMIT));

    pphd_pkg::cfg_regs_t  cfg;
    pphd_pkg::seq_ctrl_t  ctrl;

    logic s_fire;
    logic out_free;

    // tick state
    logic signed [IW-1:0]                   it_reg;
    logic signed [IW-1:0]                   it_next;
    logic signed [pphd_pkg::DERIV_W-1:0]    d_reg;
    logic signed [pphd_pkg::DERIV_W-1:0]    d_next;
    logic signed [pphd_pkg::ERR_W-1:0]      last_err_reg;
    logic signed [pphd_pkg::ERR_W-1:0]      last_err_next;

    // per-item working registers
    logic signed [pphd_pkg::ERR_W-1:0]      e_reg;
    logic signed [pphd_pkg::ERR_W-1:0]      e_next;
    logic                                   zero_reg;
    logic                                   zero_next;
    logic signed [pphd_pkg::SUM_W-1:0]      acc_reg;
    logic signed [pphd_pkg::SUM_W-1:0]      acc_next;
    logic                                   neg_reg;
    logic                                   neg_next;
    logic [pphd_pkg::QUO_W-1:0]             q_reg;
    logic [pphd_pkg::QUO_W-1:0]             q_next;

    // output register
    logic                                   m_tvalid_reg;
    logic                                   m_tvalid_next;
    logic [pphd_pkg::OUT_DATA_W-1:0]        m_tdata_reg;
    logic [pphd_pkg::OUT_DATA_W-1:0]        m_tdata_next;

    // multiplier
    logic                                   mul_en;
    logic signed [pphd_pkg::MUL_W-1:0]      mul_a;
    logic signed [pphd_pkg::MUL_W-1:0]      mul_b;
    logic signed [pphd_pkg::PROD_W-1:0]     mul_prod;

    // datapath temporaries
    logic signed [pphd_pkg::ERR_W-1:0]      e_in;
    logic signed [IW:0]                     it_sum;
    logic signed [pphd_pkg::PROD_W-1:0]     dprod_b;
    logic signed [pphd_pkg::DIFF_W-1:0]     de;
    logic signed [pphd_pkg::DQ_W-1:0]       de_ext;
    logic signed [pphd_pkg::DQ_W-1:0]       dsum;
    logic signed [pphd_pkg::SUM_W-1:0]      p_ext;
    logic signed [pphd_pkg::SUM_W-1:0]      acc_mag;
    logic [pphd_pkg::QUOT_W-1:0]            quot;
    logic signed [pphd_pkg::OUT_W-1:0]      quot_s;
    logic signed [pphd_pkg::OUT_W-1:0]      drv_raw;
    logic signed [pphd_pkg::OUT_W-1:0]      drv_sat;
    logic signed [pphd_pkg::OUT_W-1:0]      drv_neg;
    logic [pphd_pkg::DUTY_W-1:0]            fwd_duty;
    logic [pphd_pkg::DUTY_W-1:0]            bwd_duty;
    logic signed [pphd_pkg::ERR_W-1:0]      err_out;

    assign cfg_ready = 1'b1;
    assign s_tready  = ctrl.idle;
    assign s_fire    = s_tvalid & ctrl.idle;
    assign out_free  = !m_tvalid_reg || m_tready;

    pphd_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .regs     (cfg)
    );

    pphd_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_fire),
        .zero_sp  (cfg.target_position == '0),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    pphd_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    // multiplier operand select per step
    always_comb begin
        mul_en = ctrl.do_dfilt | ctrl.do_prop | ctrl.do_integ | ctrl.do_deriv
               | ctrl.do_div;
        mul_a  = '0;
        mul_b  = '0;
        if (ctrl.do_dfilt) begin
            mul_a = pphd_pkg::DFILT_COEF;
            mul_b = pphd_pkg::MUL_W'(d_reg);
        end else if (ctrl.do_prop) begin
            mul_a = pphd_pkg::MUL_W'(cfg.prop_gain);
            mul_b = pphd_pkg::MUL_W'(e_reg);
        end else if (ctrl.do_integ) begin
            mul_a = pphd_pkg::MUL_W'(cfg.integ_gain);
            mul_b = pphd_pkg::MUL_W'(it_reg);
        end else if (ctrl.do_deriv) begin
            mul_a = pphd_pkg::MUL_W'(cfg.deriv_gain);
            mul_b = pphd_pkg::MUL_W'(d_reg);
        end else if (ctrl.do_div) begin
            mul_a = pphd_pkg::MUL_W'(q_reg);
            mul_b = pphd_pkg::RECIP_TEN;
        end
    end

    // error at accept
    assign e_in = pphd_pkg::ERR_W'($signed({1'b0, cfg.target_position})
                                   - $signed({1'b0, s_tdata}));

    // integral with clamp
    always_comb begin
        it_sum = (IW+1)'(it_reg) + (IW+1)'(e_reg);
        if (it_sum > IT_HI) begin
            it_next = IW'(IT_HI);
        end else if (it_sum < IT_LO) begin
            it_next = IW'(IT_LO);
        end else begin
            it_next = IW'(it_sum);
        end
    end

    // derivative filter: trunc toward zero of 179*d/256 plus 768*(e - last)
    always_comb begin
        dprod_b = mul_prod + (mul_prod[pphd_pkg::PROD_W-1] ? pphd_pkg::PROD_W'(255)
                                                           : '0);
        de      = pphd_pkg::DIFF_W'(e_reg) - pphd_pkg::DIFF_W'(last_err_reg);
        de_ext  = pphd_pkg::DQ_W'(de);
        dsum    = pphd_pkg::DQ_W'(dprod_b >>> 8) + (de_ext <<< 9) + (de_ext <<< 8);
        if (dsum > pphd_pkg::DERIV_HI) begin
            d_next = pphd_pkg::DERIV_W'(pphd_pkg::DERIV_HI);
        end else if (dsum < pphd_pkg::DERIV_LO) begin
            d_next = pphd_pkg::DERIV_W'(pphd_pkg::DERIV_LO);
        end else begin
            d_next = pphd_pkg::DERIV_W'(dsum);
        end
    end

    // final scaling, disturbance and saturation
    always_comb begin
        p_ext   = pphd_pkg::SUM_W'(mul_prod);
        acc_mag = acc_reg[pphd_pkg::SUM_W-1] ? -acc_reg : acc_reg;
        quot    = mul_prod[pphd_pkg::RECIP_SHIFT +: pphd_pkg::QUOT_W];
        quot_s  = pphd_pkg::OUT_W'(quot);
        drv_raw = (neg_reg ? -quot_s : quot_s)
                + pphd_pkg::OUT_W'(cfg.disturbance_offset);
        if (zero_reg) begin
            drv_sat = '0;
        end else if (drv_raw > DRV_HI) begin
            drv_sat = DRV_HI;
        end else if (drv_raw < DRV_LO) begin
            drv_sat = DRV_LO;
        end else begin
            drv_sat = drv_raw;
        end
        drv_neg  = -drv_sat;
        fwd_duty = drv_sat[pphd_pkg::OUT_W-1] ? '0 : drv_sat[pphd_pkg::DUTY_W-1:0];
        bwd_duty = drv_sat[pphd_pkg::OUT_W-1] ? drv_neg[pphd_pkg::DUTY_W-1:0] : '0;
        err_out  = zero_reg ? last_err_reg : e_reg;
    end

    // register updates per step
    always_comb begin
        e_next        = e_reg;
        zero_next     = zero_reg;
        acc_next      = acc_reg;
        neg_next      = neg_reg;
        q_next        = q_reg;
        last_err_next = last_err_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (s_fire) begin
            e_next    = e_in;
            zero_next = (cfg.target_position == '0);
        end
        if (ctrl.do_integ) begin
            acc_next      = (p_ext <<< 11) + (p_ext <<< 9);
            last_err_next = e_reg;
        end
        if (ctrl.do_deriv) begin
            acc_next = acc_reg + (p_ext <<< 8);
        end
        if (ctrl.do_sum) begin
            acc_next = acc_reg + (p_ext <<< 3) + (p_ext <<< 1);
        end
        if (ctrl.do_abs) begin
            neg_next = acc_reg[pphd_pkg::SUM_W-1];
            q_next   = acc_mag[pphd_pkg::SUM_W-1:pphd_pkg::SCALE_SHIFT];
        end
        if (ctrl.do_out && out_free) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {err_out, bwd_duty, fwd_duty,
                             drv_sat[pphd_pkg::DRV_W-1:0]};
        end
    end

    // control state and tick state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            it_reg       <= '0;
            d_reg        <= '0;
            last_err_reg <= '0;
            m_tvalid_reg <= 1'b0;
            zero_reg     <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            zero_reg     <= zero_next;
            last_err_reg <= last_err_next;
            if (s_fire && (cfg.target_position == '0)) begin
                it_reg <= '0;
            end else if (ctrl.do_dfilt) begin
                it_reg <= it_next;
            end
            if (ctrl.do_prop) begin
                d_reg <= d_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        e_reg       <= e_next;
        acc_reg     <= acc_next;
        neg_reg     <= neg_next;
        q_reg       <= q_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
